FILE: src/lree_pkg.sv
// ----------------------------------------------------------------------------
// lree_pkg
// Shared widths, codes and defaults of the LED ring effect engine.
// ----------------------------------------------------------------------------
package lree_pkg;

    // pixel store word: {red, green, blue}
    localparam int PIX_W             = 24;
    localparam int PIXEL_COUNT_DEF   = 16;
    localparam int TRAIL_W           = 7;

    // input operation codes
    localparam logic [1:0] OP_FRAME    = 2'd0;
    localparam logic [1:0] OP_SET_BRT  = 2'd1;
    localparam logic [1:0] OP_FADE_OUT = 2'd2;
    localparam logic [1:0] OP_FADE_IN  = 2'd3;

    // effect modes
    localparam logic [2:0] MODE_OFF     = 3'd0;
    localparam logic [2:0] MODE_SOLID   = 3'd1;
    localparam logic [2:0] MODE_BLINK   = 3'd2;
    localparam logic [2:0] MODE_BREATHE = 3'd3;
    localparam logic [2:0] MODE_SPINNER = 3'd4;
    localparam logic [2:0] MODE_HOLD    = 3'd5;

    // configuration register indexes
    localparam logic [2:0] REG_MODE     = 3'd0;
    localparam logic [2:0] REG_RED      = 3'd1;
    localparam logic [2:0] REG_GREEN    = 3'd2;
    localparam logic [2:0] REG_BLUE     = 3'd3;
    localparam logic [2:0] REG_BLINK_P  = 3'd4;
    localparam logic [2:0] REG_SPIN_P   = 3'd5;
    localparam logic [2:0] REG_TRAIL    = 3'd6;
    localparam logic [2:0] REG_RAMP     = 3'd7;

    // configuration reset values
    localparam logic [15:0] BLINK_P_RST = 16'd500;
    localparam logic [15:0] SPIN_P_RST  = 16'd100;
    localparam logic [6:0]  TRAIL_RST   = 7'd5;
    localparam logic [7:0]  RAMP_RST    = 8'd5;
    localparam logic [7:0]  LEVEL_MAX   = 8'd255;

    typedef enum logic [1:0] {
        FADE_NONE = 2'd0,
        FADE_OUT  = 2'd1,
        FADE_IN   = 2'd2
    } t_fade;

    // what a frame does to the store
    typedef enum logic [1:0] {
        ACT_KEEP = 2'd0,
        ACT_FILL = 2'd1,
        ACT_SPIN = 2'd2
    } t_act;

    typedef struct packed {
        logic [5:0] index;
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] blue;
        logic       last;
    } t_px_out;

endpackage

FILE: src/led_ring_effect_engine_unit.sv
// ----------------------------------------------------------------------------
// led_ring_effect_engine_unit
// Frame engine for an LED ring: fades, effect redraw and pixel emission.
// ----------------------------------------------------------------------------
// A frame-tick item steps the master brightness fade, redraws the pixel
// store for the selected effect and emits PIXEL_COUNT pixel items, pixel 0
// first, tlast on the final one. Brightness loads and fade starts emit
// nothing. A frame runs through setup (fade/effect step, colour multiply,
// divide by 255), then one pixel a cycle while the output accepts, set by
// the single read-modify-write pass over the pixel store, then the last
// write-back, the return to idle and the idle cycle in which the next item
// is taken. A two-entry output queue lets the store pass run two pixels
// ahead of the consumer; beyond that a held back output stalls the pass.
// Input items are taken again once the pass has finished.
module led_ring_effect_engine_unit #(
    parameter int PIXEL_COUNT = lree_pkg::PIXEL_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_wdata,
    // input items
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,   // now_ms[31:0], brightness_value[39:32]
    input  logic [1:0]  i_s_axis_tuser,   // op[1:0]
    // pixel items
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // pixel_index[5:0], green[13:6],
                                          // red[21:14], blue[29:22], zero pad
    output logic        o_m_axis_tlast
);

    localparam int AW = $clog2(PIXEL_COUNT);
    localparam int CW = $clog2(PIXEL_COUNT + 1);
    localparam int PW = lree_pkg::PIX_W;
    localparam int TW = lree_pkg::TRAIL_W;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_STEP  = 5'b00010,
        S_MUL   = 5'b00100,
        S_SCALE = 5'b01000,
        S_RUN   = 5'b10000
    } t_state;

    // configuration
    logic [2:0]  r_mode;
    logic [7:0]  r_col_r, r_col_g, r_col_b;
    logic [15:0] r_blink_p, r_spin_p;
    logic [6:0]  r_trail;
    logic [7:0]  r_ramp;

    // effect state
    t_state          r_state;
    logic [7:0]      r_master;
    lree_pkg::t_fade r_fade;
    logic            r_blink_on;
    logic [31:0]     r_blink_stamp;
    logic [7:0]      r_br_level;
    logic            r_br_rising;
    logic [AW-1:0]   r_spin_off;
    logic [31:0]     r_spin_stamp;
    logic [31:0]     r_now;
    lree_pkg::t_act  r_act;

    // colour scaling
    logic [15:0]   r_prod_r, r_prod_g, r_prod_b;
    logic [PW-1:0] r_fill;

    // store pass and output queue
    logic [CW-1:0]     r_idx;
    logic              r_inflight;
    logic [AW-1:0]     r_rd_idx;
    logic [1:0]        r_cnt;
    logic              r_head;
    lree_pkg::t_px_out r_q [2];

    // ---------------------------------------------------------------- config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= lree_pkg::MODE_OFF;
            r_col_r   <= '0;
            r_col_g   <= '0;
            r_col_b   <= '0;
            r_blink_p <= lree_pkg::BLINK_P_RST;
            r_spin_p  <= lree_pkg::SPIN_P_RST;
            r_trail   <= lree_pkg::TRAIL_RST;
            r_ramp    <= lree_pkg::RAMP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                lree_pkg::REG_MODE:    r_mode    <= i_cfg_wdata[2:0];
                lree_pkg::REG_RED:     r_col_r   <= i_cfg_wdata[7:0];
                lree_pkg::REG_GREEN:   r_col_g   <= i_cfg_wdata[7:0];
                lree_pkg::REG_BLUE:    r_col_b   <= i_cfg_wdata[7:0];
                lree_pkg::REG_BLINK_P: r_blink_p <= i_cfg_wdata;
                lree_pkg::REG_SPIN_P:  r_spin_p  <= i_cfg_wdata;
                lree_pkg::REG_TRAIL:   r_trail   <= i_cfg_wdata[6:0];
                lree_pkg::REG_RAMP:    r_ramp    <= i_cfg_wdata[7:0];
            endcase
        end
    end

    // ------------------------------------------------------ step arithmetic
    logic [8:0]  fade_sum, br_sum;
    logic [7:0]  fade_up, fade_dn, br_up, br_dn;
    logic        blink_due, spin_due;
    logic [AW-1:0] spin_next;
    logic [PW-1:0] colour;

    assign fade_sum  = {1'b0, r_master} + {1'b0, r_ramp};
    assign fade_up   = fade_sum[8] ? lree_pkg::LEVEL_MAX : fade_sum[7:0];
    assign fade_dn   = (r_master > r_ramp) ? r_master - r_ramp : 8'd0;
    assign br_sum    = {1'b0, r_br_level} + {1'b0, r_ramp};
    assign br_up     = br_sum[8] ? lree_pkg::LEVEL_MAX : br_sum[7:0];
    assign br_dn     = (r_br_level > r_ramp) ? r_br_level - r_ramp : 8'd0;
    assign blink_due = (r_now - r_blink_stamp) > {16'd0, r_blink_p};
    assign spin_due  = (r_now - r_spin_stamp) > {16'd0, r_spin_p};
    assign spin_next = (r_spin_off == AW'(PIXEL_COUNT - 1)) ? '0 : r_spin_off + 1'b1;
    assign colour    = {r_col_r, r_col_g, r_col_b};

    // x / 255 for x <= 255*255
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [15:0] s;
        s = x + {8'd0, x[15:8]} + 16'd1;
        return s[15:8];
    endfunction

    // ------------------------------------------------------ store pass
    logic          pop, issue, push;
    logic [1:0]    occ;
    logic [PW-1:0] rd_data, new_px;
    logic [AW:0]   rel_wide;
    logic [AW-1:0] rel;
    logic          lit;
    logic          tail;

    assign pop   = o_m_axis_tvalid && i_m_axis_tready;
    assign occ   = r_cnt + {1'b0, r_inflight};
    assign issue = (r_state == S_RUN) && (r_idx != CW'(PIXEL_COUNT))
                   && ((occ < 2'd2) || pop);
    assign push  = r_inflight;
    assign tail  = r_head ^ r_cnt[0];

    // ring position of this pixel relative to the spinner head
    assign rel_wide = (r_rd_idx >= r_spin_off)
                      ? {1'b0, r_rd_idx} - {1'b0, r_spin_off}
                      : {1'b0, r_rd_idx} + (AW+1)'(PIXEL_COUNT) - {1'b0, r_spin_off};
    assign rel      = rel_wide[AW-1:0];
    assign lit      = TW'(rel) < r_trail;

    always_comb begin
        unique case (r_act)
            lree_pkg::ACT_FILL: new_px = r_fill;
            lree_pkg::ACT_SPIN: new_px = lit ? colour : '0;
            default:            new_px = rd_data;
        endcase
    end

    lree_pix_store #(
        .DEPTH (PIXEL_COUNT),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (issue),
        .i_rd_addr (r_idx[AW-1:0]),
        .o_rd_data (rd_data),
        .i_wr_en   (push),
        .i_wr_addr (r_rd_idx),
        .i_wr_data (new_px)
    );

    // ------------------------------------------------------ control
    assign o_s_axis_tready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_master      <= lree_pkg::LEVEL_MAX;
            r_fade        <= lree_pkg::FADE_NONE;
            r_blink_on    <= 1'b0;
            r_blink_stamp <= '0;
            r_br_level    <= '0;
            r_br_rising   <= 1'b1;
            r_spin_off    <= '0;
            r_spin_stamp  <= '0;
            r_act         <= lree_pkg::ACT_KEEP;
            r_idx         <= '0;
            r_inflight    <= 1'b0;
            r_cnt         <= '0;
            r_head        <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        unique case (i_s_axis_tuser)
                            lree_pkg::OP_SET_BRT:  r_master <= i_s_axis_tdata[39:32];
                            lree_pkg::OP_FADE_OUT: r_fade   <= lree_pkg::FADE_OUT;
                            lree_pkg::OP_FADE_IN:  r_fade   <= lree_pkg::FADE_IN;
                            lree_pkg::OP_FRAME:    r_state  <= S_STEP;
                        endcase
                    end
                end
                S_STEP: begin
                    unique case (r_fade)
                        lree_pkg::FADE_OUT: begin
                            r_master <= fade_dn;
                            if (fade_dn == 8'd0) r_fade <= lree_pkg::FADE_NONE;
                        end
                        lree_pkg::FADE_IN: begin
                            r_master <= fade_up;
                            if (fade_up == lree_pkg::LEVEL_MAX) r_fade <= lree_pkg::FADE_NONE;
                        end
                        default: ;
                    endcase
                    unique case (r_mode)
                        lree_pkg::MODE_OFF, lree_pkg::MODE_SOLID: r_act <= lree_pkg::ACT_FILL;
                        lree_pkg::MODE_BLINK: begin
                            if (blink_due) begin
                                r_blink_on    <= !r_blink_on;
                                r_blink_stamp <= r_now;
                                r_act         <= lree_pkg::ACT_FILL;
                            end else begin
                                r_act         <= lree_pkg::ACT_KEEP;
                            end
                        end
                        lree_pkg::MODE_BREATHE: begin
                            r_act <= lree_pkg::ACT_FILL;
                            if (r_br_rising) begin
                                r_br_level <= br_up;
                                if (br_up == lree_pkg::LEVEL_MAX) r_br_rising <= 1'b0;
                            end else begin
                                r_br_level <= br_dn;
                                if (br_dn == 8'd0) r_br_rising <= 1'b1;
                            end
                        end
                        lree_pkg::MODE_SPINNER: begin
                            if (spin_due) begin
                                r_spin_off   <= spin_next;
                                r_spin_stamp <= r_now;
                                r_act        <= lree_pkg::ACT_SPIN;
                            end else begin
                                r_act        <= lree_pkg::ACT_KEEP;
                            end
                        end
                        default: r_act <= lree_pkg::ACT_KEEP;  // hold and unused codes
                    endcase
                    r_state <= S_MUL;
                end
                S_MUL:   r_state <= S_SCALE;
                S_SCALE: begin
                    r_idx   <= '0;
                    r_state <= S_RUN;
                end
                S_RUN: begin
                    if (issue) begin
                        r_idx <= r_idx + 1'b1;
                    end else if (r_idx == CW'(PIXEL_COUNT) && !r_inflight) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            r_inflight <= issue;
            r_cnt      <= r_cnt + {1'b0, push} - {1'b0, pop};
            if (pop) begin
                r_head <= !r_head;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        logic [7:0] level;
        level = (r_mode == lree_pkg::MODE_BREATHE) ? r_br_level : r_master;
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_now <= i_s_axis_tdata[31:0];
        end
        if (r_state == S_MUL) begin
            r_prod_r <= {8'd0, r_col_r} * {8'd0, level};
            r_prod_g <= {8'd0, r_col_g} * {8'd0, level};
            r_prod_b <= {8'd0, r_col_b} * {8'd0, level};
        end
        if (r_state == S_SCALE) begin
            unique case (r_mode)
                lree_pkg::MODE_SOLID, lree_pkg::MODE_BREATHE:
                    r_fill <= {div255(r_prod_r), div255(r_prod_g), div255(r_prod_b)};
                lree_pkg::MODE_BLINK:
                    r_fill <= r_blink_on ? colour : '0;
                default:
                    r_fill <= '0;
            endcase
        end
        if (issue) begin
            r_rd_idx <= r_idx[AW-1:0];
        end
        if (push) begin
            r_q[tail].index <= 6'(r_rd_idx);
            r_q[tail].red   <= new_px[23:16];
            r_q[tail].green <= new_px[15:8];
            r_q[tail].blue  <= new_px[7:0];
            r_q[tail].last  <= (r_rd_idx == AW'(PIXEL_COUNT - 1));
        end
    end

    assign o_m_axis_tvalid = (r_cnt != 2'd0);
    assign o_m_axis_tdata  = {2'b00, r_q[r_head].blue, r_q[r_head].red,
                              r_q[r_head].green, r_q[r_head].index};
    assign o_m_axis_tlast  = r_q[r_head].last;

endmodule

FILE: src/lree_pix_store.sv
// ----------------------------------------------------------------------------
// lree_pix_store
// Pixel store: one write and one registered read port, with a valid bit per
// entry so that entries not yet written since reset read as black.
// ----------------------------------------------------------------------------
module lree_pix_store #(
    parameter int DEPTH = lree_pkg::PIXEL_COUNT_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_rd_en,
    input  logic [AW-1:0]             i_rd_addr,
    output logic [lree_pkg::PIX_W-1:0] o_rd_data,
    input  logic                      i_wr_en,
    input  logic [AW-1:0]             i_wr_addr,
    input  logic [lree_pkg::PIX_W-1:0] i_wr_data
);

    logic [lree_pkg::PIX_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]           r_valid;
    logic [lree_pkg::PIX_W-1:0] r_rd_data;
    logic                       r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule
